[rtl/srlm_pkg.sv]
// Shared types and constants for the scroll region line map.
package srlm_pkg;

  // Fixed widths of the command, result and configuration fields.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned PHYS_W   = 6;
  localparam int unsigned TOP_W    = 6;
  localparam int unsigned BOTTOM_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETLEN = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd1;

  // Register values after reset.
  localparam logic [TOP_W-1:0]    TOP_RESET    = 6'd0;
  localparam logic [BOTTOM_W-1:0] BOTTOM_RESET = 7'd64;

  // One command item.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [ROW_W-1:0]          row;
    logic signed [COUNT_W-1:0] count;
    logic [LEN_W-1:0]          new_length;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [PHYS_W-1:0] phys_line;
    logic [LEN_W-1:0]  line_length;
  } result_t;

  // Port strobes from the sequencer to one store.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

[rtl/srlm_map_ram.sv]
// Row map store: screen row to physical line, identity until written.
module srlm_map_ram #(
  parameter int unsigned ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srlm_pkg::mem_ctl_t  ctl_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] raddr_a_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] raddr_b_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] waddr_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wdata_i,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rdata_a_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rdata_b_o
);
  import srlm_pkg::*;

  localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [AW-1:0]   mem_q [ROWS];
  logic [ROWS-1:0] valid_q;
  logic [AW-1:0]   rdata_a_q;
  logic [AW-1:0]   rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // An entry that was never written still holds its own row number.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rdata_a_q <= valid_q[raddr_a_i] ? mem_q[raddr_a_i] : raddr_a_i;
      rdata_b_q <= valid_q[raddr_b_i] ? mem_q[raddr_b_i] : raddr_b_i;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/srlm_len_ram.sv]
// Line length store: one length per physical line, zero until written.
module srlm_len_ram #(
  parameter int unsigned ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srlm_pkg::mem_ctl_t  ctl_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] raddr_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] waddr_i,
  input  logic [srlm_pkg::LEN_W-1:0]                 wdata_i,
  output logic [srlm_pkg::LEN_W-1:0]                 rdata_o
);
  import srlm_pkg::*;

  logic [LEN_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]  valid_q;
  logic [LEN_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Lengths read as zero until their line is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/srlm_seq.sv]
// Command sequencer: decodes a command and walks the swaps, clears, length writes and reads.
module srlm_seq #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  srlm_pkg::item_t                   req_i,
  input  logic [srlm_pkg::TOP_W-1:0]        top_row_i,
  input  logic [srlm_pkg::BOTTOM_W-1:0]     bottom_row_i,
  output srlm_pkg::mem_ctl_t                map_ctl_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_raddr_a_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_raddr_b_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_waddr_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_wdata_o,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_rdata_a_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] map_rdata_b_i,
  output srlm_pkg::mem_ctl_t                len_ctl_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] len_raddr_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] len_waddr_o,
  output logic [srlm_pkg::LEN_W-1:0]        len_wdata_o,
  input  logic [srlm_pkg::LEN_W-1:0]        len_rdata_i,
  output logic                              result_strobe_o,
  output srlm_pkg::result_t                 result_o
);
  import srlm_pkg::*;

  localparam int unsigned AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Positions run from 0 to ROWS inclusive.
  localparam int unsigned PW  = $clog2(ROWS + 1);
  // Decode width holds positions, the bottom register and a count of 128.
  localparam int unsigned DW  = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int unsigned CLW = ($clog2(COLS + 1) > LEN_W) ? $clog2(COLS + 1) : LEN_W;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_FLIP_CHK = 11'b000_0000_0010,
    S_FLIP_WA  = 11'b000_0000_0100,
    S_FLIP_WB  = 11'b000_0000_1000,
    S_CLR_RD   = 11'b000_0001_0000,
    S_CLR_WR   = 11'b000_0010_0000,
    S_SET_RD   = 11'b000_0100_0000,
    S_SET_WR   = 11'b000_1000_0000,
    S_OUT_MAP  = 11'b001_0000_0000,
    S_OUT_LEN  = 11'b010_0000_0000,
    S_OUT_FIN  = 11'b100_0000_0000
  } state_e;

  // Which of the three reversals of a rotation is running.
  typedef enum logic [2:0] {
    PH_WHOLE = 3'b001,
    PH_HEAD  = 3'b010,
    PH_TAIL  = 3'b100
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [PW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [PW-1:0]     first_q, first_d, mid_q, mid_d, last_q, last_d;
  logic [PW-1:0]     clo_q, clo_d, chi_q, chi_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              row_ok_q, row_ok_d;
  logic [LEN_W-1:0]  nlen_q, nlen_d;
  logic              strobe_q, strobe_d;
  result_t           res_q, res_d;

  // Decode signals.
  logic              neg;
  logic [COUNT_W-1:0] cnt_u, mag;
  logic [DW-1:0]     top_w, bot_raw, rows_w, bot_w, start_w, span_w, mag_w, n_w;
  logic [DW-1:0]     mid_w, clo_w, chi_w;
  logic              is_scr, is_ins, is_rot, is_del, is_set, rot_ok, row_ok;
  logic [LEN_W-1:0]  nlen_clamped;

  // Shared pointer unit.
  logic [PW-1:0]     lo_inc, hi_dec;
  logic              swap_more, clr_more;

  // Command decode, evaluated when an item is taken.
  always_comb begin
    cnt_u   = req_i.count;
    neg     = cnt_u[COUNT_W-1];
    mag     = neg ? COUNT_W'(~cnt_u + 1'b1) : cnt_u;
    top_w   = DW'(top_row_i);
    bot_raw = DW'(bottom_row_i);
    rows_w  = DW'(ROWS);
    bot_w   = (bot_raw > rows_w) ? rows_w : bot_raw;
    is_scr  = (req_i.cmd == CMD_SCROLL);
    is_ins  = (req_i.cmd == CMD_INSERT) && !neg;
    is_del  = ((req_i.cmd == CMD_DELETE) || is_scr) && !neg;
    is_rot  = is_ins || is_del || (is_scr && neg);
    is_set  = (req_i.cmd == CMD_SETLEN);
    start_w = is_scr ? top_w : DW'(req_i.row);
    rot_ok  = is_rot && (top_w < bot_w) && (start_w >= top_w) && (start_w < bot_w)
              && (mag != '0);
    span_w  = bot_w - start_w;
    mag_w   = DW'(mag);
    n_w     = (mag_w > span_w) ? span_w : mag_w;
    mid_w   = is_ins ? (start_w + n_w) : (bot_w - n_w);
    clo_w   = is_del ? (bot_w - n_w) : start_w;
    chi_w   = is_del ? bot_w : (start_w + n_w);
    row_ok  = DW'(req_i.row) < rows_w;
    nlen_clamped = (CLW'(req_i.new_length) > CLW'(COLS)) ? LEN_W'(COLS) : req_i.new_length;
  end

  assign lo_inc    = lo_q + 1'b1;
  assign hi_dec    = hi_q - 1'b1;
  assign swap_more = (hi_q != '0) && (lo_q < hi_dec);
  assign clr_more  = (lo_q < hi_q);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    first_d  = first_q;
    mid_d    = mid_q;
    last_d   = last_q;
    clo_d    = clo_q;
    chi_d    = chi_q;
    row_d    = row_q;
    row_ok_d = row_ok_q;
    nlen_d   = nlen_q;
    strobe_d = 1'b0;
    res_d    = res_q;

    map_ctl_o     = '0;
    map_raddr_a_o = AW'(lo_q);
    map_raddr_b_o = AW'(hi_dec);
    map_waddr_o   = AW'(lo_q);
    map_wdata_o   = map_rdata_b_i;
    len_ctl_o     = '0;
    len_raddr_o   = map_rdata_a_i;
    len_waddr_o   = map_rdata_a_i;
    len_wdata_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          first_d  = PW'(start_w);
          mid_d    = PW'(mid_w);
          last_d   = PW'(bot_w);
          clo_d    = PW'(clo_w);
          chi_d    = PW'(chi_w);
          lo_d     = PW'(start_w);
          hi_d     = PW'(bot_w);
          phase_d  = PH_WHOLE;
          row_d    = req_i.row;
          row_ok_d = row_ok;
          nlen_d   = nlen_clamped;
          if (rot_ok) begin
            state_d = S_FLIP_CHK;
          end else if (is_set) begin
            state_d = S_SET_RD;
          end else begin
            state_d = S_OUT_MAP;
          end
        end
      end
      // Swap the outer pair of the range, or move on to the next reversal or, after the last, to clearing.
      S_FLIP_CHK: begin
        if (swap_more) begin
          map_ctl_o.rd = 1'b1;
          hi_d         = hi_dec;
          state_d      = S_FLIP_WA;
        end else begin
          case (phase_q)
            PH_WHOLE: begin
              phase_d = PH_HEAD;
              lo_d    = first_q;
              hi_d    = mid_q;
            end
            PH_HEAD: begin
              phase_d = PH_TAIL;
              lo_d    = mid_q;
              hi_d    = last_q;
            end
            default: begin
              lo_d    = clo_q;
              hi_d    = chi_q;
              state_d = S_CLR_RD;
            end
          endcase
        end
      end
      S_FLIP_WA: begin
        map_ctl_o.wr = 1'b1;
        map_waddr_o  = AW'(lo_q);
        map_wdata_o  = map_rdata_b_i;
        state_d      = S_FLIP_WB;
      end
      S_FLIP_WB: begin
        map_ctl_o.wr = 1'b1;
        map_waddr_o  = AW'(hi_q);
        map_wdata_o  = map_rdata_a_i;
        lo_d         = lo_inc;
        state_d      = S_FLIP_CHK;
      end
      // Zero the length of each line that lands on a vacated row.
      S_CLR_RD: begin
        if (clr_more) begin
          map_ctl_o.rd  = 1'b1;
          map_raddr_a_o = AW'(lo_q);
          state_d       = S_CLR_WR;
        end else begin
          state_d = S_OUT_MAP;
        end
      end
      S_CLR_WR: begin
        len_ctl_o.wr = 1'b1;
        len_waddr_o  = map_rdata_a_i;
        len_wdata_o  = '0;
        lo_d         = lo_inc;
        state_d      = S_CLR_RD;
      end
      S_SET_RD: begin
        map_ctl_o.rd  = 1'b1;
        map_raddr_a_o = AW'(row_q);
        state_d       = S_SET_WR;
      end
      S_SET_WR: begin
        len_ctl_o.wr = row_ok_q;
        len_waddr_o  = map_rdata_a_i;
        len_wdata_o  = nlen_q;
        state_d      = S_OUT_MAP;
      end
      // Look up the requested row and its line length.
      S_OUT_MAP: begin
        map_ctl_o.rd  = 1'b1;
        map_raddr_a_o = AW'(row_q);
        state_d       = S_OUT_LEN;
      end
      S_OUT_LEN: begin
        len_ctl_o.rd = 1'b1;
        len_raddr_o  = map_rdata_a_i;
        state_d      = S_OUT_FIN;
      end
      S_OUT_FIN: begin
        strobe_d = 1'b1;
        if (row_ok_q) begin
          res_d.phys_line   = PHYS_W'(map_rdata_a_i);
          res_d.line_length = len_rdata_i;
        end else begin
          res_d = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    first_q  <= first_d;
    mid_q    <= mid_d;
    last_q   <= last_d;
    clo_q    <= clo_d;
    chi_q    <= chi_d;
    row_q    <= row_d;
    row_ok_q <= row_ok_d;
    nlen_q   <= nlen_d;
    res_q    <= res_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

[rtl/scroll_region_line_map.sv]
// Top level of the scroll region line map: configuration registers and stores.
//
// A command item is taken at a clock edge where start is high and busy is low.
// busy then stays high until the command is done; one result item follows on
// result_o, marked by result_strobe_o for exactly one cycle, in the first
// cycle with busy low again. The receiver cannot hold results off.
// Read row, unknown commands and commands that change nothing pass S_OUT_MAP,
// S_OUT_LEN and S_OUT_FIN before the strobe; set length passes S_SET_RD and
// S_SET_WR first. Insert, delete and scroll rotate the rows from the start
// row to the region end (span L) by three reversals (S swaps, S at most L),
// each swap passing S_FLIP_CHK, S_FLIP_WA and S_FLIP_WB, then clear n rows
// through S_CLR_RD and S_CLR_WR each and end as a read row does. A new item
// can be taken in the strobe cycle. Swaps are paced by the one write port of
// the row map: each reads both entries together and writes them back singly.
// The configuration channel is always ready; the user must write top_row and
// bottom_row only while busy is low; the block itself does not enforce it.
// Reset is asynchronous and active low: the row map reads as the identity,
// all lengths as zero, top_row as 0, bottom_row as 64: no clearing pass needed.
module scroll_region_line_map #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  srlm_pkg::item_t                    req_i,
  output logic                               result_strobe_o,
  output srlm_pkg::result_t                  result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srlm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srlm_pkg::BOTTOM_W-1:0]      cfg_data_i
);
  import srlm_pkg::*;

  localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [TOP_W-1:0]    top_q;
  logic [BOTTOM_W-1:0] bottom_q;

  mem_ctl_t          map_ctl, len_ctl;
  logic [AW-1:0]     map_raddr_a, map_raddr_b, map_waddr, map_wdata;
  logic [AW-1:0]     map_rdata_a, map_rdata_b;
  logic [AW-1:0]     len_raddr, len_waddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= TOP_RESET;
      bottom_q <= BOTTOM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TOP:    top_q    <= cfg_data_i[TOP_W-1:0];
        CFG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  srlm_seq #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_i           (req_i),
    .top_row_i       (top_q),
    .bottom_row_i    (bottom_q),
    .map_ctl_o       (map_ctl),
    .map_raddr_a_o   (map_raddr_a),
    .map_raddr_b_o   (map_raddr_b),
    .map_waddr_o     (map_waddr),
    .map_wdata_o     (map_wdata),
    .map_rdata_a_i   (map_rdata_a),
    .map_rdata_b_i   (map_rdata_b),
    .len_ctl_o       (len_ctl),
    .len_raddr_o     (len_raddr),
    .len_waddr_o     (len_waddr),
    .len_wdata_o     (len_wdata),
    .len_rdata_i     (len_rdata),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  // Row map store.
  srlm_map_ram #(
    .ROWS (ROWS)
  ) u_map_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (map_ctl),
    .raddr_a_i (map_raddr_a),
    .raddr_b_i (map_raddr_b),
    .waddr_i   (map_waddr),
    .wdata_i   (map_wdata),
    .rdata_a_o (map_rdata_a),
    .rdata_b_o (map_rdata_b)
  );

  // Line length store.
  srlm_len_ram #(
    .ROWS (ROWS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (len_ctl),
    .raddr_i (len_raddr),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .rdata_o (len_rdata)
  );

  // Checks on the command sequencing.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command was taken");

  a_busy_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result strobe while a command is still running");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe held for more than one cycle");

endmodule

[tb/tb.sv]
// Self-checking testbench for the scroll region line map: predictor, driver, monitor.
module tb;
  import srlm_pkg::*;

  localparam int unsigned SCREEN_ROWS = 64;
  localparam int unsigned SCREEN_COLS = 256;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 58;
  localparam int unsigned NUM_PHASES = 12;

  // Command codes the block treats as a plain read.
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // Register indexes that hold nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  item_t                req_i;
  logic                 result_strobe_o;
  result_t              result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BOTTOM_W-1:0]  cfg_data_i;

  scroll_region_line_map #(
    .ROWS(SCREEN_ROWS),
    .COLS(SCREEN_COLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the screen map, line lengths and region registers.
  logic [PHYS_W-1:0] line_of_row [SCREEN_ROWS];
  logic [LEN_W-1:0]  len_of_line [SCREEN_ROWS];
  int unsigned       region_top;
  int unsigned       region_bottom;

  item_t   pending_cmds [$];
  result_t expected_lines [$];

  int unsigned gap_left;
  bit          no_gaps;
  logic        took_item;
  int unsigned idle_cycles;
  int unsigned mismatch_count;
  int unsigned cmds_taken;
  int unsigned lines_checked;
  int unsigned settings_used;

  // The region ends at the bottom register or at the screen edge.
  function automatic int unsigned screen_bottom();
    return (region_bottom > SCREEN_ROWS) ? SCREEN_ROWS : region_bottom;
  endfunction

  // Reverse the map entries in rows [a, b).
  function automatic void reverse_span(int unsigned a, int unsigned b);
    logic [PHYS_W-1:0] t;
    while (a + 1 < b) begin
      b--;
      t = line_of_row[a];
      line_of_row[a] = line_of_row[b];
      line_of_row[b] = t;
      a++;
    end
  endfunction

  function automatic void rotate_span(int unsigned first, int unsigned mid,
                                      int unsigned last);
    reverse_span(first, last);
    reverse_span(first, mid);
    reverse_span(mid, last);
  endfunction

  // Blank the lines that now sit on rows [a, b).
  function automatic void clear_span(int unsigned a, int unsigned b);
    for (int unsigned i = a; i < b; i++) begin
      len_of_line[line_of_row[i]] = '0;
    end
  endfunction

  function automatic void drop_region_rows(int unsigned where, int unsigned n);
    int unsigned bot;
    bot = screen_bottom();
    if (region_top >= bot || where < region_top || where >= bot || n == 0) return;
    if (n > bot - where) n = bot - where;
    rotate_span(where, bot - n, bot);
    clear_span(bot - n, bot);
  endfunction

  // Apply one command to the shadow state and return the line it reports.
  function automatic result_t apply_cmd(item_t c);
    int unsigned bot;
    int unsigned where;
    int unsigned mag;
    logic [COUNT_W-1:0] raw;
    bit neg;
    result_t r;
    bot = screen_bottom();
    where = c.row;
    raw = c.count;
    neg = raw[COUNT_W-1];
    mag = neg ? 256 - int'(raw) : int'(raw);
    case (c.cmd)
      CMD_INSERT: begin
        if (!neg && region_top < bot && where >= region_top && where < bot && mag != 0) begin
          if (mag > bot - where) mag = bot - where;
          rotate_span(where, where + mag, bot);
          clear_span(where, where + mag);
        end
      end
      CMD_DELETE: begin
        if (!neg) drop_region_rows(where, mag);
      end
      CMD_SCROLL: begin
        if (!neg) begin
          drop_region_rows(region_top, mag);
        end else if (region_top < bot) begin
          // Scrolling down opens blank rows at the top of the region.
          if (mag > bot - region_top) mag = bot - region_top;
          rotate_span(region_top, bot - mag, bot);
          clear_span(region_top, region_top + mag);
        end
      end
      CMD_SETLEN: begin
        // An 8-bit length never exceeds the column count, so no clamp applies.
        len_of_line[line_of_row[where]] = c.new_length;
      end
      default: begin
      end
    endcase
    r.phys_line = line_of_row[where];
    r.line_length = len_of_line[r.phys_line];
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (no_gaps || p < 45) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random command aimed mostly at rows and counts that hit the current region.
  function automatic item_t random_cmd();
    item_t it;
    int unsigned bot;
    int unsigned span;
    int unsigned p;
    int c;
    bot = screen_bottom();
    span = (bot > region_top) ? bot - region_top : 8;
    p = $urandom_range(99);
    it.new_length = LEN_W'($urandom);
    if (p < 30) it.cmd = CMD_SETLEN;
    else if (p < 45) it.cmd = CMD_INSERT;
    else if (p < 60) it.cmd = CMD_DELETE;
    else if (p < 75) it.cmd = CMD_SCROLL;
    else if (p < 93) it.cmd = CMD_READ;
    else if (p < 95) it.cmd = CMD_SPARE_5;
    else if (p < 97) it.cmd = CMD_SPARE_6;
    else it.cmd = CMD_SPARE_7;
    if (bot > region_top && $urandom_range(9) < 8)
      it.row = ROW_W'(region_top + $urandom_range(span - 1));
    else
      it.row = ROW_W'($urandom);
    p = $urandom_range(99);
    if (p < 70) begin
      c = ($urandom_range(3) == 0) ? $urandom_range(span, 1)
                                   : $urandom_range((span < 4) ? span : 4, 1);
    end else if (p < 80) begin
      c = 0;
    end else if (p < 90) begin
      c = $urandom_range(64, span);
    end else begin
      c = $urandom_range(255);
      c = (c > 127) ? c - 256 : c;
    end
    if (it.cmd == CMD_SCROLL && p < 90 && $urandom_range(1) == 1) c = -c;
    it.count = COUNT_W'(c);
    return it;
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int unsigned row, int count,
                                    int unsigned len);
    item_t it;
    it.cmd = cmd;
    it.row = ROW_W'(row);
    it.count = COUNT_W'(count);
    it.new_length = LEN_W'(len);
    pending_cmds.push_back(it);
  endfunction

  // Wait until every command has been taken and answered, then let the block settle.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_lines.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= BOTTOM_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_region(int unsigned top, int unsigned bottom);
    wait_drained();
    write_reg(CFG_TOP, top);
    write_reg(CFG_BOTTOM, bottom);
    settings_used++;
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver: presents queued commands on the falling edge, holding each until taken.
  always @(negedge clk_i) begin
    logic  go;
    item_t nxt;
    go = start;
    nxt = req_i;
    if (rst_ni) begin
      if (start && took_item) go = 1'b0;
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          go = 1'b1;
          gap_left = pick_gap();
        end
      end
    end else begin
      go = 1'b0;
    end
    start <= go;
    req_i <= nxt;
  end

  // Monitor: checks strobed results, predicts on each taken command, tracks register writes.
  always @(posedge clk_i) begin
    result_t want;
    bit      active;
    if (rst_ni) begin
      took_item = start && !busy;
      active = took_item || result_strobe_o || (cfg_valid_i && cfg_ready_o);
      if (result_strobe_o) begin
        lines_checked++;
        if (expected_lines.size() == 0) begin
          $error("result with no command outstanding: phys_line %0d, line_length %0d",
                 result_o.phys_line, result_o.line_length);
          mismatch_count++;
        end else begin
          want = expected_lines.pop_front();
          if (result_o.phys_line !== want.phys_line) begin
            $error("phys_line mismatch: expected %0d, actual %0d",
                   want.phys_line, result_o.phys_line);
            mismatch_count++;
          end
          if (result_o.line_length !== want.line_length) begin
            $error("line_length mismatch: expected %0d, actual %0d",
                   want.line_length, result_o.line_length);
            mismatch_count++;
          end
        end
      end
      if (took_item) begin
        expected_lines.push_back(apply_cmd(req_i));
        cmds_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TOP) region_top = cfg_data_i[TOP_W-1:0];
        else if (cfg_index_i == CFG_BOTTOM) region_bottom = cfg_data_i;
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
    end else begin
      // The shadow state follows the block's reset values.
      took_item = 1'b0;
      region_top = TOP_RESET;
      region_bottom = BOTTOM_RESET;
      for (int i = 0; i < SCREEN_ROWS; i++) begin
        line_of_row[i] = PHYS_W'(i);
        len_of_line[i] = '0;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned phase_top [NUM_PHASES];
    int unsigned phase_bot [NUM_PHASES];
    int unsigned t;
    phase_top = '{0, 63, 10, 30, 5, 0, 0, 40, 1, 0, 0, 0};
    phase_bot = '{64, 64, 20, 10, 127, 1, 0, 41, 63, 0, 0, 0};
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TOP;
    cfg_data_i = '0;
    no_gaps = 1'b0;
    settings_used = 1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset region: length extremes, clamps, null counts.
    queue_cmd(CMD_SETLEN, 0, 0, 255);
    queue_cmd(CMD_SETLEN, 63, 0, 0);
    queue_cmd(CMD_SETLEN, 63, 0, 200);
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_INSERT, 0, 1, 0);
    queue_cmd(CMD_DELETE, 0, 1, 0);
    queue_cmd(CMD_SCROLL, 0, 1, 0);
    queue_cmd(CMD_SCROLL, 63, -1, 0);
    queue_cmd(CMD_SCROLL, 5, -128, 0);
    queue_cmd(CMD_SCROLL, 62, 127, 0);
    queue_cmd(CMD_SCROLL, 1, 0, 0);
    queue_cmd(CMD_SETLEN, 5, 0, 128);
    queue_cmd(CMD_INSERT, 10, 0, 0);
    queue_cmd(CMD_DELETE, 5, -3, 0);
    queue_cmd(CMD_INSERT, 60, 64, 0);
    queue_cmd(CMD_DELETE, 63, 64, 0);
    queue_cmd(CMD_SPARE_5, 1, 0, 0);
    queue_cmd(CMD_SPARE_6, 1, 0, 0);
    queue_cmd(CMD_SPARE_7, 63, 0, 0);

    // Rows outside a partial region, then an empty region, then a bottom past the screen.
    set_region(10, 20);
    queue_cmd(CMD_INSERT, 5, 2, 0);
    queue_cmd(CMD_DELETE, 25, 1, 0);
    queue_cmd(CMD_INSERT, 19, 5, 0);
    queue_cmd(CMD_SCROLL, 0, 64, 0);
    set_region(30, 10);
    queue_cmd(CMD_INSERT, 30, 1, 0);
    queue_cmd(CMD_SCROLL, 0, -3, 0);
    set_region(0, 127);
    queue_cmd(CMD_DELETE, 60, 2, 0);

    // Random phases, each under its own region setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p >= 9) begin
        phase_top[p] = $urandom_range(63);
        phase_bot[p] = $urandom_range(127);
      end
      t = phase_top[p];
      if (p >= 9 && $urandom_range(1) == 1) t = t | 32'h40;
      set_region(t, phase_bot[p]);
      if (p == 3) begin
        write_reg(CFG_SPARE_2, $urandom_range(127));
        write_reg(CFG_SPARE_3, $urandom_range(127));
      end
      no_gaps = ($urandom_range(3) == 0);
      repeat (ITEMS_PER_PHASE) pending_cmds.push_back(random_cmd());
    end

    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("Ran %0d commands with %0d results checked across %0d region settings,",
             cmds_taken, lines_checked, settings_used);
    $display("including empty regions, a one-row region and a bottom past the screen.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[scroll_region_line_map.f]
rtl/srlm_pkg.sv
rtl/srlm_map_ram.sv
rtl/srlm_len_ram.sv
rtl/srlm_seq.sv
rtl/scroll_region_line_map.sv
tb/tb.sv
